### rtl/pif_pkg.sv
// Shared types, constants and helpers for the integer formatter.
`default_nettype none
package pif_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_C     = 8'h63;

  // Converter geometry
  localparam int DD_BITS    = 32;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 16;
  localparam int ARG_W      = 64;
  localparam int REM_W      = 5;
  localparam int DD_CNT_W   = 6;

  typedef struct packed {
    logic [7:0]       fmt_char;
    logic [ARG_W-1:0] arg_value;
  } pif_in_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        last_in_run;
    logic        string_done;
    logic [15:0] total_length;
  } pif_out_t;

  // Digit shifter control
  typedef struct packed {
    logic load;
    logic shift;
  } pif_sr_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_SIGN,
    ST_DWAIT,
    ST_SKIP,
    ST_EMIT
  } pif_state_t;

  // Nibble to ASCII, letters from the given base
  function automatic logic [7:0] nib_char(input logic [3:0] nib, input logic [7:0] letter);
    logic [7:0] n8;
    n8 = {4'b0, nib};
    if (nib >= 4'd10) begin
      nib_char = letter + n8 - 8'd10;
    end else begin
      nib_char = CH_ZERO + n8;
    end
  endfunction

endpackage
`default_nettype wire

### rtl/printf_integer_formatter_core.sv
// Top level of the printf-style integer formatter: sequencer, length count, output register.
//
// One format byte enters per transfer and gives zero to sixteen result characters,
// emitted one per cycle into an output register while it is not stalled. A plain
// byte, 'c' or '%%' takes the byte in ST_IDLE and loads the output register in ST_PUT.
// Hex takes the byte, drops leading zero nibbles in ST_SKIP and sends the digits in
// ST_EMIT. Decimal ('d', 'u') starts the bit-serial BCD converter, waits in ST_DWAIT
// for its shifts and then loads the nibble shifter, drops leading zeros from the ten
// digit positions and sends the rest; a '-' goes out while the conversion
// runs. A stalled output register holds back each character until it frees. The
// block takes one format byte at a time; a '%' alone or an unknown conversion gives no
// result. total_length is the saturating count of characters in the current string.
`default_nettype none
module printf_integer_formatter_core
  import pif_pkg::*;
#(
  parameter int LENGTH_WIDTH = 16
)(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pif_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pif_out_t      out_data
);

  localparam logic [LENGTH_WIDTH-1:0] CNT_MAX = {LENGTH_WIDTH{1'b1}};

  pif_state_t              state_r, state_nxt;
  logic                    pend_r, pend_nxt;
  logic [LENGTH_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]              pchar_r, pchar_nxt;
  logic                    pdone_r, pdone_nxt;
  logic [7:0]              letter_r, letter_nxt;
  logic                    out_valid_r;
  pif_out_t                out_data_r;

  logic                    accept, slot_free;
  logic                    push, push_last, push_done;
  logic [7:0]              push_char;
  logic [LENGTH_WIDTH-1:0] len_val;
  logic [LENGTH_WIDTH+15:0] len_ext;

  logic                    dd_start, dd_fin;
  logic [DD_BITS-1:0]      dd_value, arg_lo;
  logic [4*DEC_DIGITS-1:0] dd_bcd;

  pif_sr_ctl_t             sr_ctl;
  logic [ARG_W-1:0]        sr_ld_data;
  logic [REM_W-1:0]        sr_ld_cnt;
  logic [3:0]              sr_nib;
  logic [REM_W-1:0]        sr_remain;

  pif_dbl_dabble u_dd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dd_start),
    .value (dd_value),
    .fin   (dd_fin),
    .bcd   (dd_bcd)
  );

  pif_digit_sr u_sr (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sr_ctl),
    .ld_data (sr_ld_data),
    .ld_cnt  (sr_ld_cnt),
    .nib     (sr_nib),
    .remain  (sr_remain)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign arg_lo    = in_data.arg_value[DD_BITS-1:0];
  assign cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  // Decode and sequencing
  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    pchar_nxt  = pchar_r;
    pdone_nxt  = pdone_r;
    letter_nxt = letter_r;
    dd_start   = 1'b0;
    dd_value   = arg_lo;
    sr_ctl     = '0;
    sr_ld_data = in_data.arg_value;
    sr_ld_cnt  = REM_W'(HEX_DIGITS);
    push       = 1'b0;
    push_char  = pchar_r;
    push_last  = 1'b1;
    push_done  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pdone_nxt = 1'b0;
          if (in_data.fmt_char == CH_NUL) begin
            pend_nxt  = 1'b0;
            pchar_nxt = CH_NUL;
            pdone_nxt = 1'b1;
            state_nxt = ST_PUT;
          end else if (!pend_r) begin
            if (in_data.fmt_char == CH_PCT) begin
              pend_nxt = 1'b1;
            end else begin
              pchar_nxt = in_data.fmt_char;
              state_nxt = ST_PUT;
            end
          end else begin
            pend_nxt = 1'b0;
            case (in_data.fmt_char)
              CH_D: begin
                dd_start = 1'b1;
                if (arg_lo[DD_BITS-1]) begin
                  dd_value  = '0 - arg_lo;
                  state_nxt = ST_SIGN;
                end else begin
                  state_nxt = ST_DWAIT;
                end
              end
              CH_U: begin
                dd_start  = 1'b1;
                state_nxt = ST_DWAIT;
              end
              CH_LO_X: begin
                sr_ctl.load = 1'b1;
                letter_nxt  = CH_LO_A;
                state_nxt   = ST_SKIP;
              end
              CH_UP_X: begin
                sr_ctl.load = 1'b1;
                letter_nxt  = CH_UP_A;
                state_nxt   = ST_SKIP;
              end
              CH_C: begin
                pchar_nxt = in_data.arg_value[7:0];
                state_nxt = ST_PUT;
              end
              CH_PCT: begin
                pchar_nxt = CH_PCT;
                state_nxt = ST_PUT;
              end
              default: ;
            endcase
          end
        end
      end
      ST_PUT: begin
        push_done = pdone_r;
        if (slot_free) begin
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SIGN: begin
        push_char = CH_MINUS;
        push_last = 1'b0;
        if (slot_free) begin
          push      = 1'b1;
          state_nxt = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        letter_nxt = CH_LO_A;
        sr_ld_data = {dd_bcd, {(ARG_W-4*DEC_DIGITS){1'b0}}};
        sr_ld_cnt  = REM_W'(DEC_DIGITS);
        if (dd_fin) begin
          sr_ctl.load = 1'b1;
          state_nxt   = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sr_remain > REM_W'(1) && sr_nib == 4'd0) begin
          sr_ctl.shift = 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        push_char = nib_char(sr_nib, letter_r);
        push_last = (sr_remain == REM_W'(1));
        if (slot_free) begin
          push         = 1'b1;
          sr_ctl.shift = 1'b1;
          if (push_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Length count: the done result reports the count, then it clears
  always_comb begin
    cnt_nxt = cnt_r;
    len_val = cnt_r;
    if (push) begin
      if (push_done) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_inc;
        len_val = cnt_inc;
      end
    end
  end

  assign len_ext = {16'b0, len_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    pchar_r  <= pchar_nxt;
    pdone_r  <= pdone_nxt;
    letter_r <= letter_nxt;
    // Output register
    if (push) begin
      out_data_r.out_char     <= push_char;
      out_data_r.last_in_run  <= push_last;
      out_data_r.string_done  <= push_done;
      out_data_r.total_length <= len_ext[15:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### rtl/pif_dbl_dabble.sv
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
`default_nettype none
module pif_dbl_dabble
  import pif_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [DD_BITS-1:0]        value,
  output logic                           fin,
  output logic [4*DEC_DIGITS-1:0]        bcd
);

  logic [DD_BITS-1:0]      bin_r, bin_nxt;
  logic [4*DEC_DIGITS-1:0] bcd_r, bcd_nxt, bcd_adj;
  logic [DD_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;

  // Add 3 to every digit of five or more, then shift one bit in
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = DD_CNT_W'(DD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r != '0) begin
      bcd_nxt = {bcd_adj[4*DEC_DIGITS-2:0], bin_r[DD_BITS-1]};
      bin_nxt = {bin_r[DD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  // Result holds until the next start
  assign fin = busy_r && (cnt_r == '0);
  assign bcd = bcd_r;

endmodule
`default_nettype wire

### rtl/pif_digit_sr.sv
// Nibble shift register that feeds digits out most significant first.
`default_nettype none
module pif_digit_sr
  import pif_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pif_sr_ctl_t       ctl,
  input  wire logic [ARG_W-1:0]  ld_data,
  input  wire logic [REM_W-1:0]  ld_cnt,
  output logic [3:0]             nib,
  output logic [REM_W-1:0]       remain
);

  logic [ARG_W-1:0] data_r;
  logic [REM_W-1:0] remain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= '0;
    end else if (ctl.load) begin
      remain_r <= ld_cnt;
    end else if (ctl.shift) begin
      remain_r <= remain_r - 1'b1;
    end
    if (ctl.load) begin
      data_r <= ld_data;
    end else if (ctl.shift) begin
      data_r <= {data_r[ARG_W-5:0], 4'b0};
    end
  end

  assign nib    = data_r[ARG_W-1 -: 4];
  assign remain = remain_r;

endmodule
`default_nettype wire

### rtl/pif_checker.sv
// Port-level checks for the formatter and their binding to the top level.
`default_nettype none
module pif_checker
  import pif_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire pif_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire pif_out_t out_data
);

  // A stalled format byte holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled format byte changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The done result carries a zero character and closes its run
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.string_done |->
      out_data.out_char == 8'h00 && out_data.last_in_run)
    else $error("malformed string-done result");

  // While a result with more to follow is held, no new format byte is taken
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_in_run |-> in_stall)
    else $error("input taken in the middle of a run");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind printf_integer_formatter_core pif_checker u_pif_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
